>>> rtl/core/jasrd_pkg.sv
// ----------------------------------------------------------------------------
// jasrd_pkg
// Shared types, constants and helpers for the joystick axis scaler with a
// radial stick deadzone.
// ----------------------------------------------------------------------------
package jasrd_pkg;

  localparam int NUM_AXES  = 6;
  localparam int AXIS_W    = 3;
  localparam int SAMPLE_W  = 16;
  localparam int DZ_W      = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd3;

  localparam logic signed [15:0] RAW_MIN_RST = -16'sd32768;
  localparam logic signed [15:0] RAW_MAX_RST = 16'sd32767;
  localparam logic [DZ_W-1:0]    DZ_RST      = 15'd16384;

  localparam logic signed [15:0] Q_MAX = 16'sd32767;
  localparam logic signed [15:0] Q_MIN = -16'sd32768;

  // shared step unit widths
  localparam int REM_W = 34;
  localparam int QUO_W = 17;
  localparam int NB_W  = 32;
  localparam int CNT_W = 5;

  localparam logic [CNT_W-1:0] SCALE_STEPS = 5'd17;
  localparam logic [CNT_W-1:0] DZ_STEPS    = 5'd16;
  localparam logic [CNT_W-1:0] ROOT_STEPS  = 5'd16;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_PREP  = 16'h0002,
    ST_NUMER = 16'h0004,
    ST_DOVF  = 16'h0008,
    ST_DSTEP = 16'h0010,
    ST_DFIN  = 16'h0020,
    ST_STORE = 16'h0040,
    ST_SQX   = 16'h0080,
    ST_SQY   = 16'h0100,
    ST_SUMSQ = 16'h0200,
    ST_ROOT  = 16'h0400,
    ST_ROUND = 16'h0800,
    ST_DZ    = 16'h1000,
    ST_MDEN  = 16'h2000,
    ST_MNUM  = 16'h4000,
    ST_LOAD  = 16'h8000
  } state_t;

  typedef enum logic [1:0] {
    PH_SCALE = 2'd0,
    PH_X     = 2'd1,
    PH_Y     = 2'd2
  } phase_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

  function automatic logic signed [15:0] sat20(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = Q_MAX;
    end else if (v < -20'sd32768) begin
      r = Q_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // signed Q1.15 from a quotient magnitude and a sign
  function automatic logic signed [15:0] sat_mag(input logic [17:0] q, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > 18'd32768) ? Q_MIN : 16'(-q);
    end else begin
      r = (q > 18'd32767) ? Q_MAX : 16'(q);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/joystick_axis_scale_radial_deadzone.sv
// ----------------------------------------------------------------------------
// joystick_axis_scale_radial_deadzone
// The serial divider runs 17 steps for the scale and 16 per stick
// coordinate, the serial root 16 steps. A new sample word is taken only in
// idle, once the previous result word has been accepted; one step unit is
// shared.
// Reset: sync, clears the sequencer, config to defaults and stick store to 0.
// ----------------------------------------------------------------------------
module joystick_axis_scale_radial_deadzone (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [jasrd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jasrd_pkg::SAMPLE_W-1:0]         cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic [jasrd_pkg::AXIS_W-1:0]           axis_index,
  input  logic signed [jasrd_pkg::SAMPLE_W-1:0]  raw_sample,
  input  logic                                   invert,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [jasrd_pkg::AXIS_W-1:0]           axis_echo,
  output logic signed [jasrd_pkg::SAMPLE_W-1:0]  scaled_value,
  output logic                                   stick_valid,
  output logic signed [jasrd_pkg::SAMPLE_W-1:0]  stick_x,
  output logic signed [jasrd_pkg::SAMPLE_W-1:0]  stick_y
);

  jasrd_pkg::state_t state, state_next;
  jasrd_pkg::phase_t phase;
  logic [jasrd_pkg::CNT_W-1:0] cnt;

  logic signed [15:0] raw_min, raw_max;
  logic [jasrd_pkg::DZ_W-1:0] left_dz, right_dz;
  logic signed [15:0] axv [4];

  logic [2:0] axis;
  logic signed [15:0] raw;
  logic inv, dneg, ovf, xneg, yneg;
  logic [15:0] ad, rr, ax, ay, mag, mdz, omd;
  logic [jasrd_pkg::REM_W-1:0] rem, dvs, opa, opb;
  logic [jasrd_pkg::NB_W-1:0] nbits;
  logic [jasrd_pkg::QUO_W-1:0] quo;
  logic [31:0] prod, den;
  logic [15:0] mul_a, mul_b;
  logic signed [15:0] val, sx, sy;

  logic [jasrd_pkg::REM_W:0] cand;
  logic ge;
  logic stick, rpos, dz_zero;
  logic signed [16:0] r_full, d_full;
  logic [34:0] shifted, nmag;
  logic [32:0] load_hi;
  logic [17:0] qmag;
  logic signed [19:0] qs, vb, vi;
  logic [jasrd_pkg::DZ_W-1:0] dzsel;
  logic signed [15:0] partner, xs, ys;

  assign stick = ~axis[2];

  // shared subtract/compare unit
  always_comb begin
    case (state)
      jasrd_pkg::ST_DSTEP: begin
        opa = {rem[32:0], nbits[31]};
        opb = dvs;
      end
      jasrd_pkg::ST_ROOT: begin
        opa = {rem[31:0], nbits[31:30]};
        opb = {15'd0, quo, 2'b01};
        end
      jasrd_pkg::ST_ROUND: begin
        opa = {17'd0, quo};
        opb = rem;
      end
      default: begin
        opa = rem;
        opb = dvs;
      end
    endcase
    cand = {1'b0, opa} - {1'b0, opb};
    ge   = ~cand[jasrd_pkg::REM_W];
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      jasrd_pkg::ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      jasrd_pkg::ST_MDEN: begin
        mul_a = omd;
        mul_b = mag;
      end
      jasrd_pkg::ST_MNUM: begin
        mul_a = (phase == jasrd_pkg::PH_X) ? ax : ay;
        mul_b = mdz;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  always_comb begin
    r_full  = 17'({raw_max[15], raw_max} - {raw_min[15], raw_min});
    d_full  = 17'({raw[15], raw} - {raw_min[15], raw_min});
    rpos    = ~r_full[16] && (r_full != 17'sd0);
    shifted = stick ? ({19'd0, ad} << 17) : ({19'd0, ad} << 16);
    nmag    = dneg ? (shifted - {19'd0, rr}) : (shifted + {19'd0, rr});
    load_hi = {1'b0, prod} + {17'd0, den[31:16]};
    qmag    = ovf ? 18'h20000 : {1'b0, quo};
    qs      = dneg ? -20'(qmag + 18'(rem != '0)) : 20'(qmag);
    vb      = (stick ? -20'sd32768 : 20'sd0) + qs;
    vi      = inv ? -vb : vb;
    dzsel   = axis[1] ? right_dz : left_dz;
    dz_zero = (quo < {2'd0, dzsel}) || (quo == '0);
    partner = axv[axis[1:0] ^ 2'b01];
    xs      = axis[0] ? partner : val;
    ys      = axis[0] ? val : partner;
  end

  always_comb begin
    state_next = state;
    case (state)
      jasrd_pkg::ST_IDLE:  if (sample_valid) state_next = jasrd_pkg::ST_PREP;
      jasrd_pkg::ST_PREP: begin
        if (axis >= 3'(jasrd_pkg::NUM_AXES)) state_next = jasrd_pkg::ST_LOAD;
        else if (!rpos) state_next = jasrd_pkg::ST_STORE;
        else state_next = jasrd_pkg::ST_NUMER;
      end
      jasrd_pkg::ST_NUMER: state_next = jasrd_pkg::ST_DOVF;
      jasrd_pkg::ST_DOVF:  state_next = ge ? jasrd_pkg::ST_DFIN : jasrd_pkg::ST_DSTEP;
      jasrd_pkg::ST_DSTEP: if (cnt == 5'd1) state_next = jasrd_pkg::ST_DFIN;
      jasrd_pkg::ST_DFIN: begin
        case (phase)
          jasrd_pkg::PH_SCALE: state_next = jasrd_pkg::ST_STORE;
          jasrd_pkg::PH_X:     state_next = jasrd_pkg::ST_MNUM;
          default:             state_next = jasrd_pkg::ST_LOAD;
        endcase
      end
      jasrd_pkg::ST_STORE: state_next = stick ? jasrd_pkg::ST_SQX : jasrd_pkg::ST_LOAD;
      jasrd_pkg::ST_SQX:   state_next = jasrd_pkg::ST_SQY;
      jasrd_pkg::ST_SQY:   state_next = jasrd_pkg::ST_SUMSQ;
      jasrd_pkg::ST_SUMSQ: state_next = jasrd_pkg::ST_ROOT;
      jasrd_pkg::ST_ROOT:  if (cnt == 5'd1) state_next = jasrd_pkg::ST_ROUND;
      jasrd_pkg::ST_ROUND: state_next = jasrd_pkg::ST_DZ;
      jasrd_pkg::ST_DZ:    state_next = dz_zero ? jasrd_pkg::ST_LOAD : jasrd_pkg::ST_MDEN;
      jasrd_pkg::ST_MDEN:  state_next = jasrd_pkg::ST_MNUM;
      jasrd_pkg::ST_MNUM:  state_next = jasrd_pkg::ST_LOAD;
      jasrd_pkg::ST_LOAD: begin
        // LOAD doubles as the output hold state once the word is done
        if (result_valid) begin
          if (!result_stall) state_next = jasrd_pkg::ST_IDLE;
        end else begin
          state_next = jasrd_pkg::ST_DOVF;
        end
      end
      default: state_next = jasrd_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= jasrd_pkg::ST_IDLE;
      phase        <= jasrd_pkg::PH_SCALE;
      cnt          <= '0;
      result_valid <= 1'b0;
      raw_min      <= jasrd_pkg::RAW_MIN_RST;
      raw_max      <= jasrd_pkg::RAW_MAX_RST;
      left_dz      <= jasrd_pkg::DZ_RST;
      right_dz     <= jasrd_pkg::DZ_RST;
      for (int i = 0; i < 4; i++) axv[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          jasrd_pkg::CFG_RAW_MIN:  raw_min  <= cfg_data;
          jasrd_pkg::CFG_RAW_MAX:  raw_max  <= cfg_data;
          jasrd_pkg::CFG_LEFT_DZ:  left_dz  <= cfg_data[jasrd_pkg::DZ_W-1:0];
          jasrd_pkg::CFG_RIGHT_DZ: right_dz <= cfg_data[jasrd_pkg::DZ_W-1:0];
          default: ;
        endcase
      end
      case (state)
        jasrd_pkg::ST_PREP: begin
          phase <= jasrd_pkg::PH_SCALE;
          cnt   <= jasrd_pkg::SCALE_STEPS;
          if (axis >= 3'(jasrd_pkg::NUM_AXES)) result_valid <= 1'b1;
        end
        jasrd_pkg::ST_DSTEP, jasrd_pkg::ST_ROOT: cnt <= cnt - 5'd1;
        jasrd_pkg::ST_DFIN: begin
          if (phase == jasrd_pkg::PH_X) begin
            phase <= jasrd_pkg::PH_Y;
            cnt   <= jasrd_pkg::DZ_STEPS;
          end else if (phase == jasrd_pkg::PH_Y) begin
            result_valid <= 1'b1;
          end
        end
        jasrd_pkg::ST_STORE: begin
          if (stick) axv[axis[1:0]] <= val;
          else result_valid <= 1'b1;
        end
        jasrd_pkg::ST_SUMSQ: cnt <= jasrd_pkg::ROOT_STEPS;
        jasrd_pkg::ST_DZ: begin
          phase <= jasrd_pkg::PH_X;
          cnt   <= jasrd_pkg::DZ_STEPS;
          if (dz_zero) result_valid <= 1'b1;
        end
        jasrd_pkg::ST_LOAD: if (result_valid && !result_stall) result_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      jasrd_pkg::ST_IDLE: begin
        if (sample_valid) begin
          axis <= axis_index;
          raw  <= raw_sample;
          inv  <= invert;
        end
      end
      jasrd_pkg::ST_PREP: begin
        val  <= '0;
        sx   <= '0;
        sy   <= '0;
        dneg <= d_full[16];
        ad   <= d_full[16] ? 16'(-d_full) : d_full[15:0];
        rr   <= r_full[15:0];
      end
      jasrd_pkg::ST_NUMER: begin
        rem   <= {16'd0, nmag[34:17]};
        nbits <= {nmag[16:0], 15'd0};
        dvs   <= {17'd0, rr, 1'b0};
      end
      jasrd_pkg::ST_DOVF: begin
        ovf <= ge;
        quo <= '0;
      end
      jasrd_pkg::ST_DSTEP: begin
        rem   <= ge ? cand[jasrd_pkg::REM_W-1:0] : opa;
        quo   <= {quo[jasrd_pkg::QUO_W-2:0], ge};
        nbits <= nbits << 1;
      end
      jasrd_pkg::ST_DFIN: begin
        case (phase)
          jasrd_pkg::PH_SCALE: val <= jasrd_pkg::sat20(vi);
          jasrd_pkg::PH_X:     sx  <= jasrd_pkg::sat_mag(qmag, xneg);
          default:             sy  <= jasrd_pkg::sat_mag(qmag, yneg);
        endcase
      end
      jasrd_pkg::ST_STORE: begin
        xneg <= xs[15];
        yneg <= ys[15];
        ax   <= jasrd_pkg::abs16(xs);
        ay   <= jasrd_pkg::abs16(ys);
      end
      jasrd_pkg::ST_SQY:   nbits <= prod;
      jasrd_pkg::ST_SUMSQ: begin
        nbits <= nbits + prod;
        rem   <= '0;
        quo   <= '0;
      end
      jasrd_pkg::ST_ROOT: begin
        rem   <= ge ? cand[jasrd_pkg::REM_W-1:0] : opa;
        quo   <= {quo[jasrd_pkg::QUO_W-2:0], ge};
        nbits <= nbits << 2;
      end
      jasrd_pkg::ST_ROUND: if (!ge) quo <= quo + 17'd1;
      jasrd_pkg::ST_DZ: begin
        mag <= quo[15:0];
        mdz <= quo[15:0] - {1'b0, dzsel};
        omd <= 16'(17'd32768 - {2'd0, dzsel});
      end
      jasrd_pkg::ST_MNUM: if (phase == jasrd_pkg::PH_X) den <= prod;
      jasrd_pkg::ST_LOAD: begin
        if (!result_valid) begin
          rem   <= {1'b0, load_hi};
          nbits <= {den[15:0], 16'd0};
          dvs   <= {1'b0, den, 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign sample_stall = (state != jasrd_pkg::ST_IDLE);
  assign axis_echo    = axis;
  assign scaled_value = val;
  assign stick_valid  = stick;
  assign stick_x      = sx;
  assign stick_y      = sy;

`ifndef ASSERT_OFF
  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> !result_valid)
    else $error("result raised the cycle after a sample word");

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_stall)
    else $error("sample taken while a result word waits");

  a_trigger_pair_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !stick_valid) |-> (stick_x == 16'sd0 && stick_y == 16'sd0))
    else $error("stick pair nonzero on a non-stick word");

  a_bad_axis_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && axis_echo >= 3'(jasrd_pkg::NUM_AXES)) |-> (scaled_value == 16'sd0))
    else $error("scaled value nonzero for an out of range axis");
`endif

endmodule
